>>> rtl/qds_pkg.sv
package qds_pkg;

   localparam int KEY_W = 10;
   localparam int COUNT_W = 32;
   localparam int TALLY_W = 11;
   localparam int FRAC_W = 17;
   localparam int WEIGHT_W = 16;
   localparam int K_W = 13;

   localparam int KEY_BITS_DEF = KEY_W;
   localparam int COUNT_BITS_DEF = COUNT_W;

   localparam logic [K_W-1:0] K_RESET = K_W'(32);
   localparam int NODE_LIMIT_FACTOR = 6;
   localparam logic [FRAC_W-1:0] Q16_ONE = FRAC_W'(65536);

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic                mode;
      logic [KEY_W-1:0]    key;
      logic [WEIGHT_W-1:0] weight;
      logic [FRAC_W-1:0]   fraction;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0]   quantile_value;
      logic [COUNT_W-1:0] total_count;
      logic [TALLY_W-1:0] nodes_in_use;
      logic               overflow;
   } rsp_type;

endpackage

>>> rtl/quantile_digest_sketch_top.sv
// channel  ports                         direction  handshake
// request  start, busy, req_data         in         taken when start & !busy
// result   rsp_valid, rsp_data           out        one-cycle strobe, no stall
// config   csr_wr_en, csr_wr_data        in         written when csr_wr_en
//
// after reset a clearing pass over all 2^(KEY_BITS+1) node slots runs with busy high
// insert: one exists-memory read per level, then a read and a write of the leaf count
// compaction adds a divide of the new total by k, then a post-order walk of the tree
// query: a target rank from the total and the fraction, then a post-order walk
// results cannot be stalled; busy is low between items
module quantile_digest_sketch_top #(
   parameter int KEY_BITS = qds_pkg::KEY_BITS_DEF,
   parameter int COUNT_BITS = qds_pkg::COUNT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  qds_pkg::req_type           req_data,
   output logic                       rsp_valid,
   output qds_pkg::rsp_type           rsp_data,
   input  logic                       csr_wr_en,
   input  logic [qds_pkg::K_W-1:0]    csr_wr_data
);
   import qds_pkg::*;

   localparam int NB = KEY_BITS + 1;
   localparam int NODES = 1 << NB;
   localparam int LVL_W = $clog2(KEY_BITS + 1);
   localparam int REQ_W = COUNT_BITS + 2;
   localparam int LIM_W = K_W + 3;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_INS_RD, S_INS_CHK, S_LEAF_RD, S_LEAF_WR, S_DIV,
      S_DESC, S_DESC_CHK, S_RET, S_POST,
      S_CP0, S_CP1, S_CP2, S_CP3, S_CP4, S_CP5, S_CP6, S_CP7, S_CP8,
      S_QMUL, S_QSUM, S_QACC
   } state_type;

   state_type             state_ff;
   logic [NB-1:0]         clr_ff;
   logic [NB-1:0]         node_ff;
   logic [LVL_W-1:0]      lvl_ff;
   logic [NB-1:0]         tally_ff;
   logic [COUNT_BITS-1:0] total_ff;
   logic [K_W-1:0]        k_ff;
   req_type               item_ff;
   logic [COUNT_BITS-1:0] thr_ff;
   logic [COUNT_BITS-1:0] cnt_i_ff;
   logic [COUNT_BITS-1:0] cnt_p_ff;
   logic                  child_ff;
   logic                  exl_ff;
   logic                  exs_ff;
   logic [REQ_W-1:0]      req_ff;
   logic [REQ_W-1:0]      acc_ff;
   logic [REQ_W-1:0]      prod_hi_ff;
   logic [REQ_W-1:0]      prod_lo_ff;
   logic [KEY_BITS-1:0]   qval_ff;
   logic                  ovf_ff;
   logic                  rsp_valid_ff;

   logic                  cnt_we;
   logic [NB-1:0]         cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic [NB-1:0]         cnt_raddr;
   logic [COUNT_BITS-1:0] cnt_rdata;
   logic                  ex_we;
   logic [NB-1:0]         ex_waddr;
   logic                  ex_wdata;
   logic [NB-1:0]         ex_raddr;
   logic                  ex_rdata;

   logic [K_W-1:0]        eff_k;
   logic [LIM_W-1:0]      node_limit;
   logic [COUNT_BITS:0]   ins_sum;
   logic [NB-1:0]         leaf_w;
   logic [NB-1:0]         idx_w;
   logic                  is_leaf;
   logic [NB-1:0]         sib_w;
   logic [NB-1:0]         parent_w;
   logic [NB-1:0]         left_w;
   logic [NB-1:0]         sib_left_w;
   logic [NB:0]           span_w;
   logic [NB:0]           upper_w;
   logic [REQ_W-1:0]      fold_sum;
   logic [REQ_W-1:0]      acc_next;
   logic [FRAC_W-1:0]     frac_sat;
   logic [COUNT_BITS-1:0] leaf_new;
   logic                  div_start;
   logic                  div_done;
   logic [COUNT_BITS-1:0] div_quo;

   assign eff_k = (k_ff == '0) ? K_W'(1) : k_ff;
   assign node_limit = LIM_W'(NODE_LIMIT_FACTOR) * LIM_W'(eff_k);
   assign ins_sum = {1'b0, total_ff} + (COUNT_BITS + 1)'(req_data.weight);
   assign leaf_w = {1'b1, KEY_BITS'(item_ff.key)};
   assign idx_w = leaf_w >> (LVL_W'(KEY_BITS) - lvl_ff);
   assign is_leaf = node_ff[NB-1];
   assign sib_w = node_ff ^ NB'(1);
   assign parent_w = node_ff >> 1;
   assign left_w = {node_ff[NB-2:0], 1'b0};
   assign sib_left_w = {sib_w[NB-2:0], 1'b0};
   assign leaf_new = cnt_rdata + COUNT_BITS'(item_ff.weight);
   assign fold_sum = REQ_W'(cnt_p_ff) + REQ_W'(cnt_i_ff) + REQ_W'(cnt_rdata);
   assign acc_next = acc_ff + REQ_W'(cnt_rdata);
   assign frac_sat = (item_ff.fraction > Q16_ONE) ? Q16_ONE : item_ff.fraction;

   // upper key bound of node at level lvl: ((node - 2^lvl + 1) << (KEY_BITS - lvl)) - 1
   assign span_w = ((NB + 1)'(node_ff) - ((NB + 1)'(1) << lvl_ff) + (NB + 1)'(1))
                   << (LVL_W'(KEY_BITS) - lvl_ff);
   assign upper_w = span_w - (NB + 1)'(1);

   assign div_start = (state_ff == S_LEAF_WR)
                      && ((LIM_W'(tally_ff)) >= node_limit);

   qds_ram #(.WIDTH(COUNT_BITS), .DEPTH(NODES)) u_cnt_ram (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
      .rd_addr(cnt_raddr), .rd_data(cnt_rdata)
   );

   qds_ram #(.WIDTH(1), .DEPTH(NODES)) u_ex_ram (
      .clock(clock), .wr_en(ex_we), .wr_addr(ex_waddr), .wr_data(ex_wdata),
      .rd_addr(ex_raddr), .rd_data(ex_rdata)
   );

   qds_div #(.N(COUNT_BITS), .D(K_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(COUNT_BITS'(total_ff + COUNT_BITS'(item_ff.weight))),
      .divisor(eff_k), .done(div_done), .quotient(div_quo)
   );

   always_comb begin
      cnt_we = 1'b0;
      cnt_waddr = node_ff;
      cnt_wdata = '0;
      cnt_raddr = node_ff;
      ex_we = 1'b0;
      ex_waddr = node_ff;
      ex_wdata = 1'b0;
      ex_raddr = node_ff;
      case (state_ff)
         S_CLR: begin
            cnt_we = 1'b1;
            cnt_waddr = clr_ff;
            ex_we = 1'b1;
            ex_waddr = clr_ff;
            ex_wdata = (clr_ff == NB'(1));
         end
         S_INS_RD: ex_raddr = idx_w;
         S_INS_CHK: begin
            ex_we = !ex_rdata;
            ex_waddr = idx_w;
            ex_wdata = 1'b1;
         end
         S_LEAF_RD: cnt_raddr = leaf_w;
         S_LEAF_WR: begin
            cnt_we = 1'b1;
            cnt_waddr = leaf_w;
            cnt_wdata = leaf_new;
         end
         S_CP0: ex_raddr = left_w;
         S_CP1: ex_raddr = left_w | NB'(1);
         S_CP2: begin
            if (cnt_i_ff == '0 && !(!is_leaf && (exl_ff || ex_rdata))) begin
               ex_we = 1'b1;
            end
            cnt_raddr = parent_w;
            ex_raddr = sib_w;
         end
         S_CP3: cnt_raddr = sib_w;
         S_CP4: begin
            cnt_we = fold_sum < REQ_W'(thr_ff);
            cnt_waddr = parent_w;
            cnt_wdata = COUNT_BITS'(fold_sum);
         end
         S_CP5: begin
            cnt_we = 1'b1;
            ex_we = !child_ff;
         end
         S_CP6: begin
            cnt_we = 1'b1;
            cnt_waddr = sib_w;
            ex_we = is_leaf;
            ex_waddr = sib_w;
            ex_raddr = sib_left_w;
         end
         S_CP7: ex_raddr = sib_left_w | NB'(1);
         S_CP8: begin
            ex_we = !(exl_ff || ex_rdata);
            ex_waddr = sib_w;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         tally_ff <= NB'(1);
         total_ff <= '0;
         k_ff <= K_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_wr_en) begin
            k_ff <= csr_wr_data;
         end
         case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == NB'(NODES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  item_ff <= req_data;
                  qval_ff <= '0;
                  ovf_ff <= 1'b0;
                  if (req_data.mode == MODE_QUERY) begin
                     state_ff <= S_QMUL;
                  end else if (ins_sum[COUNT_BITS]) begin
                     ovf_ff <= 1'b1;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     lvl_ff <= LVL_W'(1);
                     state_ff <= S_INS_RD;
                  end
               end
            end
            S_INS_RD: state_ff <= S_INS_CHK;
            S_INS_CHK: begin
               if (!ex_rdata) begin
                  tally_ff <= tally_ff + 1'b1;
               end
               if (lvl_ff == LVL_W'(KEY_BITS)) begin
                  state_ff <= S_LEAF_RD;
               end else begin
                  lvl_ff <= lvl_ff + 1'b1;
                  state_ff <= S_INS_RD;
               end
            end
            S_LEAF_RD: state_ff <= S_LEAF_WR;
            S_LEAF_WR: begin
               total_ff <= total_ff + COUNT_BITS'(item_ff.weight);
               if (div_start) begin
                  state_ff <= S_DIV;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  thr_ff <= div_quo;
                  node_ff <= NB'(1);
                  lvl_ff <= '0;
                  state_ff <= S_DESC;
               end
            end
            S_DESC: state_ff <= S_DESC_CHK;
            S_DESC_CHK: begin
               if (!ex_rdata) begin
                  state_ff <= S_RET;
               end else if (!is_leaf) begin
                  node_ff <= left_w;
                  lvl_ff <= lvl_ff + 1'b1;
                  state_ff <= S_DESC;
               end else begin
                  state_ff <= S_POST;
               end
            end
            S_RET: begin
               if (node_ff == NB'(1)) begin
                  if (item_ff.mode == MODE_QUERY) begin
                     qval_ff <= '1;
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (!node_ff[0]) begin
                  node_ff <= node_ff | NB'(1);
                  state_ff <= S_DESC;
               end else begin
                  node_ff <= parent_w;
                  lvl_ff <= lvl_ff - 1'b1;
                  state_ff <= S_POST;
               end
            end
            S_POST: begin
               if (item_ff.mode == MODE_QUERY) begin
                  state_ff <= S_QACC;
               end else if (node_ff == NB'(1)) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_CP0;
               end
            end
            S_CP0: state_ff <= S_CP1;
            S_CP1: begin
               cnt_i_ff <= cnt_rdata;
               exl_ff <= ex_rdata;
               state_ff <= S_CP2;
            end
            S_CP2: begin
               child_ff <= !is_leaf && (exl_ff || ex_rdata);
               if (cnt_i_ff == '0 && !(!is_leaf && (exl_ff || ex_rdata))) begin
                  tally_ff <= tally_ff - 1'b1;
                  state_ff <= S_RET;
               end else begin
                  state_ff <= S_CP3;
               end
            end
            S_CP3: begin
               cnt_p_ff <= cnt_rdata;
               exs_ff <= ex_rdata;
               state_ff <= S_CP4;
            end
            S_CP4: begin
               state_ff <= (fold_sum < REQ_W'(thr_ff)) ? S_CP5 : S_RET;
            end
            S_CP5: begin
               if (!child_ff) begin
                  tally_ff <= tally_ff - 1'b1;
               end
               state_ff <= exs_ff ? S_CP6 : S_RET;
            end
            S_CP6: begin
               if (is_leaf) begin
                  tally_ff <= tally_ff - 1'b1;
                  state_ff <= S_RET;
               end else begin
                  state_ff <= S_CP7;
               end
            end
            S_CP7: begin
               exl_ff <= ex_rdata;
               state_ff <= S_CP8;
            end
            S_CP8: begin
               if (!(exl_ff || ex_rdata)) begin
                  tally_ff <= tally_ff - 1'b1;
               end
               state_ff <= S_RET;
            end
            S_QMUL: begin
               prod_hi_ff <= REQ_W'(((COUNT_BITS + FRAC_W)'(total_ff) >> 16)
                                    * (COUNT_BITS + FRAC_W)'(frac_sat));
               prod_lo_ff <= REQ_W'(((16 + FRAC_W)'(total_ff[15:0])
                                     * (16 + FRAC_W)'(frac_sat)) >> 16);
               state_ff <= S_QSUM;
            end
            S_QSUM: begin
               req_ff <= prod_hi_ff + prod_lo_ff;
               acc_ff <= '0;
               node_ff <= NB'(1);
               lvl_ff <= '0;
               if (prod_hi_ff + prod_lo_ff == '0) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_DESC;
               end
            end
            S_QACC: begin
               acc_ff <= acc_next;
               if (acc_next >= req_ff) begin
                  qval_ff <= KEY_BITS'(upper_w);
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_RET;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.quantile_value = KEY_W'(qval_ff);
   assign rsp_data.total_count = COUNT_W'(total_ff);
   assign rsp_data.nodes_in_use = TALLY_W'(tally_ff);
   assign rsp_data.overflow = ovf_ff;

`ifndef SYNTHESIS
   a_tally_nonzero: assert property (@(posedge clock) disable iff (reset)
      tally_ff != '0)
      else $error("node tally reached zero");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_ovf_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> rsp_data.quantile_value == '0)
      else $error("refused insert carries a quantile value");

   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> total_ff >= $past(total_ff))
      else $error("weight total decreased");
`endif
endmodule

>>> rtl/qds_ram.sv
module qds_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/qds_div.sv
module qds_div #(
   parameter int N = 32,
   parameter int D = 13
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         done,
   output logic [N-1:0] quotient
);
   localparam int CW = $clog2(N + 1);

   logic [N-1:0]  quo_ff;
   logic [D-1:0]  rem_ff;
   logic [D-1:0]  dsr_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [D:0]    trial;
   logic          fits;

   // one quotient bit per cycle, restoring
   assign trial = {rem_ff, quo_ff[N-1]};
   assign fits = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            quo_ff <= dividend;
            rem_ff <= '0;
            dsr_ff <= divisor;
            cnt_ff <= CW'(N);
         end else if (busy_ff) begin
            rem_ff <= fits ? D'(trial - {1'b0, dsr_ff}) : D'(trial);
            quo_ff <= {quo_ff[N-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

>>> test/qds_checker.sv
module qds_checker
   import qds_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [K_W-1:0]   csr_wr_data,
   output int               fail_count,
   output int               pending
);

   localparam int SLOTS = 2 ** (KEY_W + 1);
   localparam int LEAF0 = 2 ** KEY_W;

   logic [63:0] cnt [SLOTS];
   bit          live [SLOTS];
   logic [63:0] sum_w;
   int          tally;
   logic [K_W-1:0] k_reg;
   rsp_type     want_q [$];

   function automatic bit kids(int i);
      if (i >= LEAF0) return 0;
      return live[2*i] || live[2*i+1];
   endfunction

   function automatic bit prune(int i);
      if (live[i] && cnt[i] == 0 && !kids(i)) begin
         live[i] = 0;
         tally--;
         return 1;
      end
      return 0;
   endfunction

   function automatic void squeeze(int i, logic [63:0] thr);
      int p;
      logic [63:0] s;
      if (!live[i]) return;
      if (i < LEAF0) begin
         squeeze(2*i, thr);
         squeeze(2*i+1, thr);
      end
      if (i == 1) return;
      if (prune(i)) return;
      p = i >> 1;
      s = cnt[p] + cnt[2*p] + cnt[2*p+1];
      if (s < thr) begin
         cnt[p] = s;
         for (int c = 2*p; c <= 2*p+1; c++)
            if (live[c]) begin
               cnt[c] = 0;
               void'(prune(c));
            end
      end
   endfunction

   function automatic int upper_key(int i);
      int lvl, span;
      lvl = $clog2(i + 1) - 1;
      span = 1 << (KEY_W - lvl);
      return (i - (1 << lvl)) * span + span - 1;
   endfunction

   function automatic bit rank_find(int i, ref logic [63:0] acc, input logic [63:0] goal,
                                    ref int val);
      if (!live[i]) return 0;
      if (i < LEAF0) begin
         if (rank_find(2*i, acc, goal, val)) return 1;
         if (rank_find(2*i+1, acc, goal, val)) return 1;
      end
      acc += cnt[i];
      if (acc >= goal) begin
         val = upper_key(i);
         return 1;
      end
      return 0;
   endfunction

   function automatic rsp_type digest_step(req_type r);
      rsp_type o;
      logic [63:0] kk, fr, goal, acc;
      int leaf, val;
      kk = (k_reg == 0) ? 64'd1 : 64'(k_reg);
      o = '0;
      if (r.mode == MODE_INSERT) begin
         if (64'(r.weight) > 64'hFFFF_FFFF - sum_w) o.overflow = 1'b1;
         else begin
            leaf = LEAF0 + int'(r.key);
            for (int l = 1; l <= KEY_W; l++)
               if (!live[leaf >> (KEY_W - l)]) begin
                  live[leaf >> (KEY_W - l)] = 1;
                  tally++;
               end
            cnt[leaf] += r.weight;
            sum_w += r.weight;
            if (64'(tally) >= 6 * kk) squeeze(1, sum_w / kk);
         end
      end else begin
         fr = (r.fraction > Q16_ONE) ? 64'(Q16_ONE) : 64'(r.fraction);
         goal = (sum_w >> 16) * fr + (((sum_w & 64'hFFFF) * fr) >> 16);
         val = 0;
         acc = 0;
         if (goal != 0 && !rank_find(1, acc, goal, val)) val = upper_key(1);
         o.quantile_value = KEY_W'(val);
      end
      o.total_count = sum_w[31:0];
      o.nodes_in_use = TALLY_W'(tally);
      return o;
   endfunction

   assign pending = want_q.size();

   always @(posedge clock) begin
      rsp_type w;
      if (reset) begin
         foreach (cnt[i]) begin
            cnt[i] = 0;
            live[i] = 0;
         end
         live[1] = 1;
         sum_w = 0;
         tally = 1;
         k_reg = K_RESET;
         want_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (want_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               w = want_q.pop_front();
               if (w !== rsp_data) begin
                  fail_count++;
                  if (fail_count <= 10) $display("mismatch exp %p got %p", w, rsp_data);
               end
            end
         end
         if (csr_wr_en) k_reg = csr_wr_data;
         if (start && !busy) want_q.push_back(digest_step(req_data));
      end
   end

endmodule

>>> test/tb.sv
module tb;
   import qds_pkg::*;

   logic clock = 0, reset = 1, start = 0, busy, rsp_valid, csr_wr_en = 0;
   req_type req_data = '0;
   rsp_type rsp_data;
   logic [K_W-1:0] csr_wr_data = '0;
   int fail_count, pending, idle_cycles, gap_pct;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   quantile_digest_sketch_top DUT (.*);

   qds_checker chk (.*);

   // stall counter: cycles with no item or result moving
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 200000) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic send(req_type r);
      while ($urandom_range(99) < gap_pct) @(posedge clock);
      start <= 1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_k(int k);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= K_W'(k);
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   function automatic req_type rand_item(int hot);
      req_type r;
      r.mode = ($urandom_range(99) < 70) ? MODE_INSERT : MODE_QUERY;
      r.key = hot ? KEY_W'($urandom_range(15) * 64 + $urandom_range(3)) : KEY_W'($urandom);
      case ($urandom_range(3))
         0: r.weight = '1;
         1: r.weight = WEIGHT_W'($urandom_range(3));
         default: r.weight = WEIGHT_W'($urandom);
      endcase
      case ($urandom_range(4))
         0: r.fraction = Q16_ONE;
         1: r.fraction = FRAC_W'($urandom);
         default: r.fraction = FRAC_W'($urandom_range(65536));
      endcase
      return r;
   endfunction

   initial begin
      int ks[6] = '{1, 4096, 2, 0, 8191, 5};
      gap_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (busy) @(posedge clock);
      // directed: empty query, extremes, zero weight, saturated fraction
      send('{MODE_QUERY, '0, '0, Q16_ONE});
      send('{MODE_INSERT, '0, '0, '0});
      send('{MODE_INSERT, '1, '1, '1});
      send('{MODE_QUERY, '1, '1, '1});
      send('{MODE_QUERY, '0, '0, FRAC_W'(1)});
      send('{MODE_QUERY, '0, '0, FRAC_W'(32768)});
      for (int i = 0; i < 10; i++)
         send('{MODE_INSERT, KEY_W'(i * 113), WEIGHT_W'(i * 7001), '0});
      send('{MODE_QUERY, '0, '0, FRAC_W'(65535)});
      // large k: no folding while the digest is small
      set_k(4096);
      send('{MODE_INSERT, '1, '1, '0});
      send('{MODE_QUERY, '0, '0, FRAC_W'(40000)});
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         set_k(ks[ph]);
         gap_pct = (ph < 2) ? 20 : ((ph < 4) ? 61 : 0);
         for (int n = 0; n < 290; n++) send(rand_item(ph % 2));
         if (ph == 2) begin
            drain();
            send(rand_item(0));
         end
      end
      drain();
      if (fail_count == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end
endmodule
